FILE: rtl/core/rcadsr_pkg.sv
// Shared types, constants and the raised-cosine curve table for the ADSR envelope.
package rcadsr_pkg;

    localparam int PHASE_FRAC_BITS = 24;
    localparam int LEVEL_FRAC_BITS = 16;
    localparam int COS_TABLE_BITS  = 8;

    localparam int PHASE_W   = PHASE_FRAC_BITS + 1;
    localparam int LEVEL_W   = LEVEL_FRAC_BITS + 1;
    localparam int IDX_W     = COS_TABLE_BITS + 1;
    localparam int TABLE_N   = 1 << COS_TABLE_BITS;
    localparam int CFG_W     = (PHASE_W > LEVEL_W) ? PHASE_W : LEVEL_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;
    // about -60 dB of full scale
    localparam logic [LEVEL_W-1:0] SLEEP_RESET =
        LEVEL_W'(((1 << LEVEL_FRAC_BITS) + 500) / 1000);

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef enum logic [1:0] {
        ST_ATTACK  = 2'd0,
        ST_DECAY   = 2'd1,
        ST_SUSTAIN = 2'd2,
        ST_RELEASE = 2'd3
    } t_stage;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_STEP  = 3'd0,
        CFG_DECAY_STEP   = 3'd1,
        CFG_RELEASE_STEP = 3'd2,
        CFG_SUSTAIN      = 3'd3,
        CFG_SLEEP_THR    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               active;
        t_stage             stage;
    } t_result;

    typedef logic [LEVEL_W-1:0] t_curve [0:TABLE_N];

    // shift-and-subtract quotient, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          b;
        q   = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // 13-term Taylor cosine in Q30, used only while building the table
    function automatic logic [63:0] cos_q30(input logic [63:0] theta);
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        div;
        logic signed [63:0] sum;
        int                 k;
        t2   = (theta * theta) >> 30;
        term = Q30_ONE;
        sum  = $signed(Q30_ONE);
        for (k = 1; k <= 12; k++) begin
            div  = 64'((2 * k - 1) * (2 * k));
            term = udiv64((term * t2) >> 30, div);
            if ((k & 1) != 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        return $unsigned(sum);
    endfunction

    // r[i] = (1 + cos(pi*i/N)) / 2 in Q1.16, mirrored about the midpoint
    function automatic t_curve build_curve();
        t_curve      tbl;
        logic [63:0] theta;
        logic [63:0] c;
        logic [63:0] r;
        int          i;
        for (i = 0; i < TABLE_N / 2; i++) begin
            theta = (PI_Q30 * 64'(i) + 64'(TABLE_N / 2)) / TABLE_N;
            c     = cos_q30(theta);
            r     = (((Q30_ONE + c) << LEVEL_FRAC_BITS) + Q30_ONE) >> 31;
            if (r > 64'(LEVEL_ONE)) begin
                r = 64'(LEVEL_ONE);
            end
            tbl[i]           = LEVEL_W'(r);
            tbl[TABLE_N - i] = LEVEL_W'(64'(LEVEL_ONE) - r);
        end
        tbl[TABLE_N / 2] = LEVEL_ONE >> 1;
        return tbl;
    endfunction

    localparam t_curve CURVE = build_curve();

endpackage

FILE: rtl/core/raised_cosine_adsr_envelope.sv
// Raised-cosine ADSR envelope: one tick in, one level/active/stage word out.
// A result word is registered into the output register, or into the skid word while the output waits.
// Throughput: one tick per cycle while o_in_stall is low; the whole retrigger chain, one table lookup and one
//   17x17 multiply sit between the state registers and the output register.
// A two-word output buffer (register plus skid) lets a tick be taken while a result waits.
// Reset (sync, active low): release stage, finished and idle, level 0, steps and sustain
//   at 1.0, sleep threshold at about -60 dB.
module raised_cosine_adsr_envelope (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [rcadsr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcadsr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_note_on,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rcadsr_pkg::LEVEL_W-1:0]   o_level,
    output logic                            o_active,
    output logic [1:0]                      o_stage
);

    // ---------------- configuration registers ----------------
    logic [rcadsr_pkg::PHASE_W-1:0] r_attack_step;
    logic [rcadsr_pkg::PHASE_W-1:0] r_decay_step;
    logic [rcadsr_pkg::PHASE_W-1:0] r_release_step;
    logic [rcadsr_pkg::LEVEL_W-1:0] r_sustain;
    logic [rcadsr_pkg::LEVEL_W-1:0] r_sleep_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_step  <= rcadsr_pkg::PHASE_ONE;
            r_decay_step   <= rcadsr_pkg::PHASE_ONE;
            r_release_step <= rcadsr_pkg::PHASE_ONE;
            r_sustain      <= rcadsr_pkg::LEVEL_ONE;
            r_sleep_thr    <= rcadsr_pkg::SLEEP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (rcadsr_pkg::t_cfg_idx'(i_cfg_idx))
                rcadsr_pkg::CFG_ATTACK_STEP:
                    r_attack_step  <= i_cfg_data[rcadsr_pkg::PHASE_W-1:0];
                rcadsr_pkg::CFG_DECAY_STEP:
                    r_decay_step   <= i_cfg_data[rcadsr_pkg::PHASE_W-1:0];
                rcadsr_pkg::CFG_RELEASE_STEP:
                    r_release_step <= i_cfg_data[rcadsr_pkg::PHASE_W-1:0];
                rcadsr_pkg::CFG_SUSTAIN:
                    r_sustain      <= i_cfg_data[rcadsr_pkg::LEVEL_W-1:0];
                rcadsr_pkg::CFG_SLEEP_THR:
                    r_sleep_thr    <= i_cfg_data[rcadsr_pkg::LEVEL_W-1:0];
                default: ; // unused indexes are dropped
            endcase
        end
    end

    // ---------------- envelope state ----------------
    rcadsr_pkg::t_stage             r_stage, n_stage;
    logic [rcadsr_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [rcadsr_pkg::LEVEL_W-1:0] r_level, n_level;
    logic [rcadsr_pkg::LEVEL_W-1:0] r_start, n_start;

    // handshake
    logic                r_out_valid;
    logic                r_skid_valid;
    rcadsr_pkg::t_result r_out;
    rcadsr_pkg::t_result r_skid;
    rcadsr_pkg::t_result n_res;
    logic                in_accept;
    logic                out_take;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid & ~r_skid_valid;
    assign out_take   = r_out_valid & ~i_out_stall;

    // ---------------- operand selection ----------------
    // Sustain is clamped to full scale. Attack entered from release starts at the
    // current level with phase 0; release entered from a gated stage does the same.
    logic [rcadsr_pkg::LEVEL_W-1:0] sus;
    logic [rcadsr_pkg::LEVEL_W-1:0] att_start;
    logic [rcadsr_pkg::LEVEL_W-1:0] rel_start;
    logic [rcadsr_pkg::PHASE_W-1:0] att_phase;
    logic [rcadsr_pkg::PHASE_W-1:0] rel_phase;
    logic                           rel_enter;
    logic                           dec_mode;
    logic [rcadsr_pkg::PHASE_W-1:0] phase_sel;
    logic [rcadsr_pkg::PHASE_W-1:0] step_sel;

    assign sus       = (r_sustain > rcadsr_pkg::LEVEL_ONE) ? rcadsr_pkg::LEVEL_ONE : r_sustain;
    assign att_start = (r_stage == rcadsr_pkg::ST_RELEASE) ? r_level : r_start;
    assign att_phase = (r_stage == rcadsr_pkg::ST_RELEASE) ? '0 : r_phase;
    assign rel_enter = (r_stage != rcadsr_pkg::ST_RELEASE);
    assign rel_start = rel_enter ? r_level : r_start;
    assign rel_phase = rel_enter ? '0 : r_phase;
    assign dec_mode  = i_note_on & (r_stage == rcadsr_pkg::ST_DECAY);

    assign phase_sel = !i_note_on ? rel_phase : (dec_mode ? r_phase : att_phase);
    assign step_sel  = !i_note_on ? r_release_step : (dec_mode ? r_decay_step : r_attack_step);

    // ---------------- curve lookup ----------------
    // Index is the phase truncated to table bits; a full phase hits the last entry.
    logic [rcadsr_pkg::IDX_W-1:0]   curve_idx;
    logic [rcadsr_pkg::LEVEL_W-1:0] curve_val;

    assign curve_idx = phase_sel[rcadsr_pkg::PHASE_FRAC_BITS] ?
        rcadsr_pkg::IDX_W'(rcadsr_pkg::TABLE_N) :
        {1'b0, phase_sel[rcadsr_pkg::PHASE_FRAC_BITS-1 -: rcadsr_pkg::COS_TABLE_BITS]};
    assign curve_val = rcadsr_pkg::CURVE[curve_idx];

    // ---------------- shared multiplier ----------------
    // attack:  (1 - r) * (1 - start)
    // decay:   r * (1 - sus)
    // release: start * r
    logic [rcadsr_pkg::LEVEL_W-1:0]   mul_a;
    logic [rcadsr_pkg::LEVEL_W-1:0]   mul_b;
    logic [2*rcadsr_pkg::LEVEL_W-1:0] prod;
    logic [2*rcadsr_pkg::LEVEL_W:0]   prod_rnd;
    logic [rcadsr_pkg::LEVEL_W-1:0]   mul_out;

    assign mul_a = !i_note_on ? rel_start :
                   (dec_mode ? curve_val : rcadsr_pkg::LEVEL_ONE - curve_val);
    assign mul_b = !i_note_on ? curve_val :
                   (dec_mode ? rcadsr_pkg::LEVEL_ONE - sus : rcadsr_pkg::LEVEL_ONE - att_start);
    assign prod     = mul_a * mul_b;
    assign prod_rnd = {1'b0, prod}
                    + ((2*rcadsr_pkg::LEVEL_W+1)'(1) << (rcadsr_pkg::LEVEL_FRAC_BITS - 1));
    assign mul_out  = prod_rnd[rcadsr_pkg::LEVEL_FRAC_BITS +: rcadsr_pkg::LEVEL_W];

    // ---------------- phase advance, saturating at 1.0 ----------------
    logic [rcadsr_pkg::PHASE_W:0]   phase_sum;
    logic                           phase_end;
    logic [rcadsr_pkg::PHASE_W-1:0] phase_adv;
    logic                           dec_first_end;

    assign phase_sum     = {1'b0, phase_sel} + {1'b0, step_sel};
    assign phase_end     = (phase_sum >= {1'b0, rcadsr_pkg::PHASE_ONE});
    assign phase_adv     = phase_end ? rcadsr_pkg::PHASE_ONE : phase_sum[rcadsr_pkg::PHASE_W-1:0];
    // a decay step of 1.0 or more ends decay on its first step, so a finished attack goes straight to sustain
    assign dec_first_end = (r_decay_step >= rcadsr_pkg::PHASE_ONE);

    // ---------------- next state ----------------
    logic [rcadsr_pkg::LEVEL_W:0] lvl_sum;

    always_comb begin
        n_stage = r_stage;
        n_phase = r_phase;
        n_start = r_start;
        lvl_sum = {1'b0, r_level};
        if (i_note_on) begin
            unique case (r_stage) inside
                rcadsr_pkg::ST_RELEASE, rcadsr_pkg::ST_ATTACK: begin
                    n_start = att_start;
                    if (phase_end) begin
                        // attack done: decay at phase 0 gives exactly full scale
                        if (dec_first_end) begin
                            n_stage = rcadsr_pkg::ST_SUSTAIN;
                            n_phase = rcadsr_pkg::PHASE_ONE;
                            lvl_sum = {1'b0, sus};
                        end else begin
                            n_stage = rcadsr_pkg::ST_DECAY;
                            n_phase = r_decay_step;
                            lvl_sum = {1'b0, rcadsr_pkg::LEVEL_ONE};
                        end
                    end else begin
                        n_stage = rcadsr_pkg::ST_ATTACK;
                        n_phase = phase_adv;
                        lvl_sum = {1'b0, att_start} + {1'b0, mul_out};
                    end
                end
                rcadsr_pkg::ST_DECAY: begin
                    n_phase = phase_adv;
                    if (phase_end) begin
                        n_stage = rcadsr_pkg::ST_SUSTAIN;
                        lvl_sum = {1'b0, sus};
                    end else begin
                        lvl_sum = {1'b0, sus} + {1'b0, mul_out};
                    end
                end
                rcadsr_pkg::ST_SUSTAIN: begin
                    lvl_sum = {1'b0, sus};
                end
            endcase
        end else begin
            n_stage = rcadsr_pkg::ST_RELEASE;
            n_start = rel_start;
            // a finished release idles and keeps its level
            if (rel_phase < rcadsr_pkg::PHASE_ONE) begin
                n_phase = phase_adv;
                lvl_sum = phase_end ? '0 : {1'b0, mul_out};
            end
        end

        n_level = (lvl_sum > {1'b0, rcadsr_pkg::LEVEL_ONE}) ?
                  rcadsr_pkg::LEVEL_ONE : lvl_sum[rcadsr_pkg::LEVEL_W-1:0];

        n_res.level  = n_level;
        n_res.active = i_note_on | (n_level >= r_sleep_thr);
        n_res.stage  = n_stage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= rcadsr_pkg::ST_RELEASE;
            r_phase <= rcadsr_pkg::PHASE_ONE;
            r_level <= '0;
            r_start <= '0;
        end else if (in_accept) begin
            r_stage <= n_stage;
            r_phase <= n_phase;
            r_level <= n_level;
            r_start <= n_start;
        end
    end

    // ---------------- output register and skid word ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (r_out_valid && !out_take) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_out.level;
    assign o_active    = r_out.active;
    assign o_stage     = r_out.stage;

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= rcadsr_pkg::PHASE_ONE)
        else $error("envelope phase above 1.0");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.level <= rcadsr_pkg::LEVEL_ONE))
        else $error("output level above full scale");

    a_gate_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_note_on) |=> (r_stage == rcadsr_pkg::ST_RELEASE))
        else $error("gate off did not land in release");

    a_gate_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_note_on) |=> (r_stage != rcadsr_pkg::ST_RELEASE))
        else $error("gate on left envelope in release");
`endif

endmodule
